// ===== rtl/core/opu_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the orbit phase and position update block.
// No dependencies; opu_trig, the top module and the testbench refer to it by scoped names.
package opu_pkg;

	localparam logic OP_LOAD    = 1'b0;
	localparam logic OP_ADVANCE = 1'b1;

	localparam int RED_W     = 40;
	localparam int Z_W       = 33;
	localparam int XY_W      = 34;
	localparam int MAX_STEPS = 32;
	localparam int RED_STAGES = 7;

	localparam logic signed [29:0] TWO_PI_Q20    = 30'sd6588397;
	localparam logic signed [29:0] ANGLE_MAX_Q20 = 30'sd134217727;
	localparam logic signed [29:0] ANGLE_MIN_Q20 = -30'sd134217728;

	localparam logic signed [RED_W-1:0] TWO_PI_Q30  = 40'sd6746518852;
	localparam logic signed [RED_W-1:0] PI_Q30      = 40'sd3373259426;
	localparam logic signed [RED_W-1:0] HALF_PI_Q30 = 40'sd1686629713;
	localparam logic signed [XY_W-1:0]  GAIN_Q30    = 34'sd652032874;
	localparam logic [24:0]             DEG_TO_RAD_Q30 = 25'd18740330;

	typedef struct packed {
		logic               operation;
		logic [7:0]         body_index;
		logic signed [27:0] start_angle;
		logic [19:0]        time_step;
		logic signed [23:0] angular_speed;
		logic [31:0]        orbit_radius;
		logic signed [31:0] center_x;
		logic signed [31:0] center_y;
		logic signed [31:0] center_z;
		logic signed [15:0] inclination;
	} in_word_t;

	typedef struct packed {
		logic signed [27:0] new_angle;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic               overflow;
	} out_word_t;

	typedef struct packed {
		logic signed [27:0] angle;
		logic               ovf;
		logic [31:0]        radius;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic signed [31:0] cz;
	} side_t;

	function automatic logic [29:0] atan_q30(input logic [4:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0:  v = 30'd843314857;
			5'd1:  v = 30'd497837829;
			5'd2:  v = 30'd263043837;
			5'd3:  v = 30'd133525159;
			5'd4:  v = 30'd67021687;
			5'd5:  v = 30'd33543516;
			5'd6:  v = 30'd16775851;
			5'd7:  v = 30'd8388437;
			5'd8:  v = 30'd4194283;
			5'd9:  v = 30'd2097149;
			5'd31: v = 30'd0;
			default: v = 30'd1 << (5'd30 - i);
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/opu_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module opu_ram #(
	parameter int WIDTH = 28,
	parameter int DEPTH = 256
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/core/opu_trig.sv =====
`timescale 1ns / 1ps
// Two-lane pipelined sine/cosine: range reduction to [-pi/2, pi/2], then one
// CORDIC rotation per stage. Depends on opu_pkg.
module opu_trig #(
	parameter int STEPS = 20,
	parameter int TAG_W = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              src_valid,
	input  logic signed [opu_pkg::RED_W-1:0]  src_a,
	input  logic signed [opu_pkg::RED_W-1:0]  src_b,
	input  logic [TAG_W-1:0]                  src_tag,
	output logic                              dst_valid,
	output logic [TAG_W-1:0]                  dst_tag,
	output logic signed [opu_pkg::XY_W-1:0]   cos_a,
	output logic signed [opu_pkg::XY_W-1:0]   sin_a,
	output logic signed [opu_pkg::XY_W-1:0]   sin_b
);
	localparam int N  = (STEPS < opu_pkg::MAX_STEPS) ? STEPS : opu_pkg::MAX_STEPS;
	localparam int NR = opu_pkg::RED_STAGES;

	logic                              rv_q   [NR+1];
	logic [TAG_W-1:0]                  rtag_q [NR+1];
	logic signed [opu_pkg::RED_W-1:0]  rz_q   [NR+1][2];

	logic                              cv_q   [N+1];
	logic [TAG_W-1:0]                  ctag_q [N+1];
	logic signed [opu_pkg::Z_W-1:0]    cz_q   [N+1][2];
	logic signed [opu_pkg::XY_W-1:0]   cx_q   [N+1][2];
	logic signed [opu_pkg::XY_W-1:0]   cy_q   [N+1][2];
	logic                              cf_q   [N+1][2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_q[0] <= 1'b0;
		end else if (en) begin
			rv_q[0] <= src_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rtag_q[0]  <= src_tag;
			rz_q[0][0] <= src_a;
			rz_q[0][1] <= src_b;
		end
	end

	for (genvar j = 1; j <= NR; j++) begin : g_red
		localparam logic signed [opu_pkg::RED_W-1:0] OFS =
			opu_pkg::TWO_PI_Q30 <<< ((j == 1) ? 5 : (NR - j));
		logic signed [opu_pkg::RED_W-1:0] nz [2];
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				if (j == 1) begin
					nz[l] = (rz_q[j-1][l] < 0) ? rz_q[j-1][l] + OFS : rz_q[j-1][l];
				end else begin
					nz[l] = (rz_q[j-1][l] >= OFS) ? rz_q[j-1][l] - OFS : rz_q[j-1][l];
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rv_q[j] <= 1'b0;
			end else if (en) begin
				rv_q[j] <= rv_q[j-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				rtag_q[j] <= rtag_q[j-1];
				rz_q[j]   <= nz;
			end
		end
	end

	logic signed [opu_pkg::RED_W-1:0] fz [2];
	logic                             ff [2];
	always_comb begin
		for (int l = 0; l < 2; l++) begin
			fz[l] = (rz_q[NR][l] > opu_pkg::PI_Q30) ? rz_q[NR][l] - opu_pkg::TWO_PI_Q30
				: rz_q[NR][l];
			ff[l] = 1'b0;
			if (fz[l] > opu_pkg::HALF_PI_Q30) begin
				fz[l] = fz[l] - opu_pkg::PI_Q30;
				ff[l] = 1'b1;
			end else if (fz[l] < -opu_pkg::HALF_PI_Q30) begin
				fz[l] = fz[l] + opu_pkg::PI_Q30;
				ff[l] = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_q[0] <= 1'b0;
		end else if (en) begin
			cv_q[0] <= rv_q[NR];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctag_q[0] <= rtag_q[NR];
			for (int l = 0; l < 2; l++) begin
				cz_q[0][l] <= opu_pkg::Z_W'(fz[l]);
				cx_q[0][l] <= opu_pkg::GAIN_Q30;
				cy_q[0][l] <= '0;
				cf_q[0][l] <= ff[l];
			end
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_rot
		logic signed [opu_pkg::Z_W-1:0] ang;
		logic signed [opu_pkg::Z_W-1:0]  nz [2];
		logic signed [opu_pkg::XY_W-1:0] nx [2];
		logic signed [opu_pkg::XY_W-1:0] ny [2];
		assign ang = signed'({3'b000, opu_pkg::atan_q30(5'(i))});
		always_comb begin
			for (int l = 0; l < 2; l++) begin
				if (cz_q[i][l] >= 0) begin
					nx[l] = cx_q[i][l] - (cy_q[i][l] >>> i);
					ny[l] = cy_q[i][l] + (cx_q[i][l] >>> i);
					nz[l] = cz_q[i][l] - ang;
				end else begin
					nx[l] = cx_q[i][l] + (cy_q[i][l] >>> i);
					ny[l] = cy_q[i][l] - (cx_q[i][l] >>> i);
					nz[l] = cz_q[i][l] + ang;
				end
			end
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_q[i+1] <= 1'b0;
			end else if (en) begin
				cv_q[i+1] <= cv_q[i];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				ctag_q[i+1] <= ctag_q[i];
				cz_q[i+1]   <= nz;
				cx_q[i+1]   <= nx;
				cy_q[i+1]   <= ny;
				cf_q[i+1]   <= cf_q[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid <= 1'b0;
		end else if (en) begin
			dst_valid <= cv_q[N];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dst_tag <= ctag_q[N];
			cos_a   <= cf_q[N][0] ? -cx_q[N][0] : cx_q[N][0];
			sin_a   <= cf_q[N][0] ? -cy_q[N][0] : cy_q[N][0];
			sin_b   <= cf_q[N][1] ? -cy_q[N][1] : cy_q[N][1];
		end
	end
endmodule

// ===== rtl/core/orbit_phase_position_update.sv =====
`timescale 1ns / 1ps
// Orbit phase and position update: one word in per cycle while item_stall is low,
// one result word out per input word. Words pass s1, s2, the range reduction,
// the CORDIC pipeline (one rotation per stage) and m1 to m3. The angle table
// (MAX_BODIES entries) sits in one RAM read at acceptance and written one
// stage later; a same-body word directly behind takes the angle by forwarding,
// so back-to-back words on one body sustain one per cycle unless held. A stalled
// result holds the whole pipeline only once its last stage is occupied.
// Depends on opu_pkg, opu_ram and opu_trig.
module orbit_phase_position_update #(
	parameter int MAX_BODIES   = 256,
	parameter int CORDIC_STEPS = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  opu_pkg::in_word_t  item,
	output logic               result_valid,
	input  logic               result_stall,
	output opu_pkg::out_word_t result
);
	localparam int IDX_W = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

	function automatic logic [IDX_W-1:0] body_slot(input logic [7:0] b);
		logic [31:0] r;
		r = {24'd0, b};
		for (int k = 7; k >= 0; k--) begin
			if (r >= (32'(MAX_BODIES) << k)) begin
				r = r - (32'(MAX_BODIES) << k);
			end
		end
		return IDX_W'(r);
	endfunction

	function automatic logic [32:0] sat32(input logic signed [37:0] v);
		logic [32:0] o;
		if (v > 38'sd2147483647) begin
			o = {1'b1, 32'h7fff_ffff};
		end else if (v < -38'sd2147483648) begin
			o = {1'b1, 32'h8000_0000};
		end else begin
			o = {1'b0, v[31:0]};
		end
		return o;
	endfunction

	logic en;
	logic accept;
	logic v_m3;

	assign en         = !(result_valid && result_stall && v_m3);
	assign item_stall = !en;
	assign accept     = item_valid && en;

	// stage 1: table read returns
	logic                 v_s1;
	logic                 op_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic signed [27:0]   start_s1;
	logic signed [44:0]   prod_s1;
	logic signed [41:0]   incl_s1;
	opu_pkg::side_t       side_s1;
	logic [MAX_BODIES-1:0] seen_q;
	logic                 seen_rd_q;

	logic [IDX_W-1:0]     rd_addr;
	logic [27:0]          rd_data;
	logic                 ram_we;
	logic [27:0]          ram_wdata;

	assign rd_addr = en ? body_slot(item.body_index) : idx_s1;

	opu_ram #(.WIDTH(28), .DEPTH(MAX_BODIES)) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_s1),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			seen_q    <= '0;
			seen_rd_q <= 1'b0;
		end else begin
			seen_rd_q <= seen_q[rd_addr];
			if (ram_we) begin
				seen_q[idx_s1] <= 1'b1;
			end
			if (en) begin
				v_s1 <= accept;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1    <= item.operation;
			idx_s1   <= body_slot(item.body_index);
			start_s1 <= item.start_angle;
			prod_s1  <= 45'(item.angular_speed) * 45'(signed'({1'b0, item.time_step}));
			incl_s1  <= 42'(item.inclination) *
				42'(signed'({1'b0, opu_pkg::DEG_TO_RAD_Q30}));
			side_s1.angle  <= '0;
			side_s1.ovf    <= 1'b0;
			side_s1.radius <= item.orbit_radius;
			side_s1.cx     <= item.center_x;
			side_s1.cy     <= item.center_y;
			side_s1.cz     <= item.center_z;
		end
	end

	// stage 2: new angle registered and forwarded
	logic                 v_s2;
	logic [IDX_W-1:0]     idx_s2;
	logic signed [27:0]   angle_s2;
	logic signed [41:0]   incl_s2;
	opu_pkg::side_t       side_s2;

	logic signed [27:0]   base;
	logic signed [29:0]   sum;
	logic signed [29:0]   wrapped;
	logic signed [27:0]   adv;
	logic                 adv_ovf;
	logic signed [27:0]   ang_new;
	logic                 ang_ovf;

	always_comb begin
		if (v_s2 && idx_s2 == idx_s1) begin
			base = angle_s2;
		end else begin
			base = seen_rd_q ? signed'(rd_data) : 28'sd0;
		end
		sum     = 30'(base) + 30'(prod_s1 >>> 16);
		wrapped = (sum > opu_pkg::TWO_PI_Q20) ? sum - opu_pkg::TWO_PI_Q20 : sum;
		adv_ovf = 1'b1;
		if (wrapped > opu_pkg::ANGLE_MAX_Q20) begin
			adv = 28'(opu_pkg::ANGLE_MAX_Q20);
		end else if (wrapped < opu_pkg::ANGLE_MIN_Q20) begin
			adv = 28'(opu_pkg::ANGLE_MIN_Q20);
		end else begin
			adv     = wrapped[27:0];
			adv_ovf = 1'b0;
		end
		if (op_s1 == opu_pkg::OP_LOAD) begin
			ang_new = start_s1;
			ang_ovf = 1'b0;
		end else begin
			ang_new = adv;
			ang_ovf = adv_ovf;
		end
	end

	assign ram_we    = en && v_s1;
	assign ram_wdata = ang_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			idx_s2   <= idx_s1;
			angle_s2 <= ang_new;
			incl_s2  <= incl_s1;
			side_s2  <= {ang_new, ang_ovf, side_s1.radius, side_s1.cx, side_s1.cy,
				side_s1.cz};
		end
	end

	// trig pipeline
	logic                            tr_valid;
	opu_pkg::side_t                  tr_side;
	logic signed [opu_pkg::XY_W-1:0] cos_a;
	logic signed [opu_pkg::XY_W-1:0] sin_a;
	logic signed [opu_pkg::XY_W-1:0] sin_b;

	opu_trig #(.STEPS(CORDIC_STEPS), .TAG_W($bits(opu_pkg::side_t))) u_trig (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.src_valid (v_s2),
		.src_a     (40'(angle_s2) <<< 10),
		.src_b     (40'(incl_s2 >>> 7)),
		.src_tag   (side_s2),
		.dst_valid (tr_valid),
		.dst_tag   (tr_side),
		.cos_a     (cos_a),
		.sin_a     (sin_a),
		.sin_b     (sin_b)
	);

	// products and sums
	logic                 v_m1;
	opu_pkg::side_t       side_m1;
	logic signed [66:0]   px_m1;
	logic signed [66:0]   pz_m1;
	logic signed [67:0]   pt_m1;

	logic                 v_m2;
	opu_pkg::side_t       side_m2;
	logic signed [37:0]   xs_m2;
	logic signed [37:0]   zs_m2;
	logic signed [66:0]   py_m2;

	opu_pkg::side_t       side_m3;
	logic signed [37:0]   xs_m3;
	logic signed [37:0]   ys_m3;
	logic signed [37:0]   zs_m3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_m1 <= 1'b0;
			v_m2 <= 1'b0;
			v_m3 <= 1'b0;
		end else if (en) begin
			v_m1 <= tr_valid;
			v_m2 <= v_m1;
			v_m3 <= v_m2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_m1 <= tr_side;
			px_m1   <= 67'(signed'({1'b0, tr_side.radius})) * 67'(cos_a);
			pz_m1   <= 67'(signed'({1'b0, tr_side.radius})) * 67'(sin_a);
			pt_m1   <= 68'(sin_a) * 68'(sin_b);

			side_m2 <= side_m1;
			xs_m2   <= 38'(side_m1.cx) + 38'(px_m1 >>> 30);
			zs_m2   <= 38'(side_m1.cz) + 38'(pz_m1 >>> 30);
			py_m2   <= 67'(signed'({1'b0, side_m1.radius})) *
				67'(opu_pkg::XY_W'(pt_m1 >>> 30));

			side_m3 <= side_m2;
			xs_m3   <= xs_m2;
			zs_m3   <= zs_m2;
			ys_m3   <= 38'(side_m2.cy) + 38'(py_m2 >>> 30);
		end
	end

	logic [32:0] sx;
	logic [32:0] sy;
	logic [32:0] sz;
	assign sx = sat32(xs_m3);
	assign sy = sat32(ys_m3);
	assign sz = sat32(zs_m3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en && v_m3) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en && v_m3) begin
			result.new_angle <= side_m3.angle;
			result.pos_x     <= sx[31:0];
			result.pos_y     <= sy[31:0];
			result.pos_z     <= sz[31:0];
			result.overflow  <= side_m3.ovf | sx[32] | sy[32] | sz[32];
		end
	end

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted word did not reach stage 1");

	a_write_forwards: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> (v_s2 && angle_s2 == $past(ram_wdata)))
		else $error("written angle not held for forwarding");

	a_result_from_tail: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(v_m3))
		else $error("result word without a tail entry");

	a_hold_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!en |-> (result_valid && result_stall))
		else $error("pipeline held without an output stall");
endmodule

// ===== bench/orbit_phase_position_update_test.sv =====
`timescale 1ns / 1ps
// Testbench of orbit_phase_position_update: a table of directed words, then random words.
// Each result is checked against the angle table and CORDIC predictor kept here, or a typed want.
// Depends on opu_pkg and the RTL of the block.
module orbit_phase_position_update_test;

	localparam int       N_RANDOM    = 630;
	localparam int       CYCLE_LIMIT = 400000;
	localparam longint   TWO_PI_A    = 64'sd6588397;
	localparam longint   TWO_PI_T    = 64'sd6746518852;
	localparam longint   PI_T        = 64'sd3373259426;
	localparam longint   HALF_PI_T   = 64'sd1686629713;
	localparam longint   K_GAIN      = 64'sd652032874;
	localparam longint   DEG_RAD     = 64'sd18740330;
	localparam longint   ANG_HI      = 64'sd134217727;
	localparam longint   ANG_LO      = -64'sd134217728;
	localparam longint   ROT_STEPS   = 20;
	localparam longint   ARCTAN [0:31] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516, 16775851,
		8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072, 65536, 32768,
		16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0};

	typedef struct {
		opu_pkg::in_word_t  w;
		bit                 typed;
		opu_pkg::out_word_t want;
	} row_t;

	logic               clk;
	logic               arst_n;
	logic               item_valid;
	logic               item_stall;
	opu_pkg::in_word_t  item;
	logic               result_valid;
	logic               result_stall;
	opu_pkg::out_word_t result;

	logic signed [27:0] orbit_angle [0:255];
	opu_pkg::out_word_t pending [$];
	row_t               rows [$];
	int                 errors;
	int                 cycles;
	int                 taken;
	bit                 sending_done;

	orbit_phase_position_update dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	task automatic sin_cos(input longint a, output longint c, output longint s);
		longint r, x, y, nx;
		bit     flip;
		r = a % TWO_PI_T;
		x = K_GAIN;
		y = 0;
		flip = 1'b0;
		if (r < 0) r += TWO_PI_T;
		if (r > PI_T) r -= TWO_PI_T;
		if (r > HALF_PI_T) begin
			r -= PI_T;
			flip = 1'b1;
		end else if (r < -HALF_PI_T) begin
			r += PI_T;
			flip = 1'b1;
		end
		for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
			if (r >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				r -= ARCTAN[i];
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				r += ARCTAN[i];
			end
			x = nx;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endtask

	function automatic longint clamp32(input longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// advance or load one body, then place it on its inclined orbit
	task automatic place_body(input opu_pkg::in_word_t w, output opu_pkg::out_word_t o);
		longint ang, rad, ca, sa, ci, si, t;
		bit     ovf;
		ovf = 1'b0;
		if (w.operation == opu_pkg::OP_LOAD) begin
			ang = longint'(w.start_angle);
		end else begin
			ang = longint'(orbit_angle[w.body_index])
				+ ((longint'(w.angular_speed) * longint'({1'b0, w.time_step})) >>> 16);
			if (ang > TWO_PI_A) ang -= TWO_PI_A;
			if (ang > ANG_HI) begin
				ang = ANG_HI;
				ovf = 1'b1;
			end
			if (ang < ANG_LO) begin
				ang = ANG_LO;
				ovf = 1'b1;
			end
		end
		orbit_angle[w.body_index] = ang[27:0];
		rad = longint'({1'b0, w.orbit_radius});
		sin_cos(ang * 1024, ca, sa);
		sin_cos((longint'(w.inclination) * DEG_RAD) >>> 7, ci, si);
		o.new_angle = ang[27:0];
		o.pos_x = 32'(clamp32(longint'(w.center_x) + ((rad * ca) >>> 30), ovf));
		o.pos_z = 32'(clamp32(longint'(w.center_z) + ((rad * sa) >>> 30), ovf));
		t = (sa * si) >>> 30;
		o.pos_y = 32'(clamp32(longint'(w.center_y) + ((rad * t) >>> 30), ovf));
		o.overflow = ovf;
	endtask

	function automatic opu_pkg::in_word_t word_of(input logic op, input logic [7:0] body,
			input longint ang, input longint step, input longint spd, input longint rad,
			input longint cx, input longint cy, input longint cz, input longint incl);
		opu_pkg::in_word_t w;
		w.operation = op;
		w.body_index = body;
		w.start_angle = ang[27:0];
		w.time_step = step[19:0];
		w.angular_speed = spd[23:0];
		w.orbit_radius = rad[31:0];
		w.center_x = cx[31:0];
		w.center_y = cy[31:0];
		w.center_z = cz[31:0];
		w.inclination = incl[15:0];
		return w;
	endfunction

	function automatic row_t plain(input opu_pkg::in_word_t w);
		row_t r;
		r.w = w;
		r.typed = 1'b0;
		r.want = '0;
		return r;
	endfunction

	function automatic row_t typed(input opu_pkg::in_word_t w, input longint ang,
			input bit ovf);
		row_t r;
		r.w = w;
		r.typed = 1'b1;
		r.want.new_angle = ang[27:0];
		r.want.pos_x = w.center_x;
		r.want.pos_y = w.center_y;
		r.want.pos_z = w.center_z;
		r.want.overflow = ovf;
		return r;
	endfunction

	function automatic longint pick_wide(input int bits);
		longint v;
		v = {$urandom, $urandom};
		return (v << (64 - bits)) >>> (64 - bits);
	endfunction

	function automatic opu_pkg::in_word_t random_word();
		opu_pkg::in_word_t w;
		w.operation = $urandom_range(0, 3) != 0 ? opu_pkg::OP_ADVANCE : opu_pkg::OP_LOAD;
		w.body_index = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) : 8'($urandom);
		w.start_angle = $urandom_range(0, 3) == 0 ? 28'($urandom)
			: 28'(pick_wide(24));
		w.time_step = 20'($urandom);
		w.angular_speed = $urandom_range(0, 3) == 0 ? 24'($urandom) : 24'(pick_wide(19));
		w.orbit_radius = $urandom_range(0, 2) == 0 ? $urandom : 32'($urandom_range(0, 1 << 24));
		w.center_x = $urandom_range(0, 2) == 0 ? $urandom : 32'(pick_wide(26));
		w.center_y = $urandom_range(0, 2) == 0 ? $urandom : 32'(pick_wide(26));
		w.center_z = $urandom_range(0, 2) == 0 ? $urandom : 32'(pick_wide(26));
		w.inclination = 16'($urandom);
		return w;
	endfunction

	task automatic send_word(input opu_pkg::in_word_t w, input row_t r, input bit quiet);
		opu_pkg::out_word_t o;
		int                 gap;
		gap = quiet ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= w;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		place_body(w, o);
		pending.push_back(r.typed ? r.want : o);
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_stall = 1'b0;
		errors = 0;
		sending_done = 1'b0;
		for (int i = 0; i < 256; i++) orbit_angle[i] = '0;

		rows.push_back(typed(word_of(opu_pkg::OP_ADVANCE, 0, 0, 0, 0, 0, 0, 0, 0, 0),
			0, 0));
		rows.push_back(typed(word_of(opu_pkg::OP_LOAD, 1, ANG_HI, 0, 0, 0,
			2147483647, -2147483648, -1, 0), ANG_HI, 0));
		rows.push_back(typed(word_of(opu_pkg::OP_ADVANCE, 1, 0, 1048575, 8388607, 0,
			5, 6, 7, -32768), ANG_HI, 1));
		rows.push_back(typed(word_of(opu_pkg::OP_LOAD, 2, ANG_LO, 0, 0, 0,
			1, 2, 3, 32767), ANG_LO, 0));
		rows.push_back(typed(word_of(opu_pkg::OP_ADVANCE, 2, 0, 1048575, -8388608, 0,
			-1, -2, -3, 0), ANG_LO, 1));
		rows.push_back(plain(word_of(opu_pkg::OP_LOAD, 255, 0, 0, 0, 4294967295,
			2147483647, 2147483647, 2147483647, 32767)));
		rows.push_back(plain(word_of(opu_pkg::OP_LOAD, 128, 3294199, 0, 0, 4294967295,
			-2147483648, -2147483648, -2147483648, -32768)));
		rows.push_back(plain(word_of(opu_pkg::OP_LOAD, 4, 6588000, 0, 0, 65536,
			0, 0, 0, 11520)));
		rows.push_back(plain(word_of(opu_pkg::OP_ADVANCE, 4, 0, 1024, 65536, 65536,
			0, 0, 0, 11520)));
		rows.push_back(plain(word_of(opu_pkg::OP_ADVANCE, 4, 0, 1048575, 8388607, 65536,
			0, 0, 0, -11520)));
		rows.push_back(plain(word_of(opu_pkg::OP_ADVANCE, 4, 0, 1048575, 8388607, 65536,
			0, 0, 0, 5760)));
		rows.push_back(plain(word_of(opu_pkg::OP_LOAD, 5, 1647099, 0, 0, 100 << 16,
			0, 0, 0, 23040)));
		rows.push_back(plain(word_of(opu_pkg::OP_LOAD, 6, -1647099, 0, 0, 100 << 16,
			0, 0, 0, -23040)));
		rows.push_back(plain(word_of(opu_pkg::OP_ADVANCE, 6, 0, 1048575, -8388608, 100 << 16,
			0, 0, 0, 0)));
		rows.push_back(plain(word_of(opu_pkg::OP_ADVANCE, 6, 0, 1048575, -8388608, 100 << 16,
			0, 0, 0, 0)));
		rows.push_back(plain(word_of(opu_pkg::OP_LOAD, 7, -3294199, 0, 0, 4294967295,
			2147483647, 0, -2147483648, 11520)));
		rows.push_back(plain(word_of(opu_pkg::OP_ADVANCE, 1, 0, 1, 1, 1, 0, 0, 0, 1)));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) send_word(rows[i].w, rows[i], i % 2 == 0);
		for (int i = 0; i < N_RANDOM; i++) begin
			opu_pkg::in_word_t w;
			w = random_word();
			send_word(w, plain(w), (i / 64) % 3 == 1);
		end
		item_valid <= 1'b0;
		sending_done = 1'b1;
	end

	// receiver stall: random hold per word, with quiet stretches
	initial begin
		wait (arst_n);
		@(posedge clk);
		forever begin
			if ((taken / 64) % 3 != 2) begin
				int n;
				n = $urandom_range(0, 17);
				if (n > 0) begin
					result_stall <= 1'b1;
					repeat (n) @(posedge clk);
					result_stall <= 1'b0;
				end
			end
			do @(posedge clk); while (!(result_valid && !result_stall));
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			taken <= taken + 1;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t unexpected word: got %p", $time, result);
			end else begin
				opu_pkg::out_word_t e;
				e = pending.pop_front();
				if (result.new_angle !== e.new_angle) begin
					errors++;
					$display("%0t new_angle: want %0d got %0d", $time, e.new_angle,
						result.new_angle);
				end
				if (result.pos_x !== e.pos_x) begin
					errors++;
					$display("%0t pos_x: want %0d got %0d", $time, e.pos_x, result.pos_x);
				end
				if (result.pos_y !== e.pos_y) begin
					errors++;
					$display("%0t pos_y: want %0d got %0d", $time, e.pos_y, result.pos_y);
				end
				if (result.pos_z !== e.pos_z) begin
					errors++;
					$display("%0t pos_z: want %0d got %0d", $time, e.pos_z, result.pos_z);
				end
				if (result.overflow !== e.overflow) begin
					errors++;
					$display("%0t overflow: want %0d got %0d", $time, e.overflow,
						result.overflow);
				end
			end
		end
	end

	initial begin
		taken = 0;
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		wait (sending_done);
		while (pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/opu_pkg.sv
rtl/core/opu_ram.sv
rtl/core/opu_trig.sv
rtl/core/orbit_phase_position_update.sv
bench/orbit_phase_position_update_test.sv
